### sv/elcu_pkg.sv
// Package with lattice constants, types and codes shared by the cell update modules.
package elcu_pkg;

  // Lattice geometry.
  localparam int GRID_SIZE = 128;
  localparam int CW        = $clog2(GRID_SIZE);
  localparam int AW        = 2 * CW;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;
  localparam int STATE_W   = 11;

  typedef logic [AW-1:0]             addr_t;
  typedef logic [CW-1:0]             coord_t;
  typedef logic signed [STATE_W-1:0] state_t;
  typedef logic [1:0]                bank_t;

  // Cell state codes.
  localparam state_t STATE_EXCITED = state_t'(1);
  localparam state_t STATE_REST    = state_t'(0);
  localparam state_t STATE_LAST    = state_t'(-1);

  // Item actions.
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  // Register indexes of the write port.
  localparam logic [1:0] REG_REFRACTORY = 2'd0;
  localparam logic [1:0] REG_PACEMAKER  = 2'd1;
  localparam logic [1:0] REG_THRESHOLD  = 2'd2;

  // Register reset values.
  localparam logic [9:0]  RST_REFRACTORY = 10'd50;
  localparam logic [9:0]  RST_PACEMAKER  = 10'd220;
  localparam logic [15:0] RST_THRESHOLD  = 16'd3277;

  // State bank identifiers.
  localparam bank_t BANK0 = 2'd0;
  localparam bank_t BANK1 = 2'd1;
  localparam bank_t BANK2 = 2'd2;

  // Read addresses for one cell and its four neighbors.
  typedef struct packed {
    addr_t own;
    addr_t left;
    addr_t right;
    addr_t up;
    addr_t down;
  } nbr_addr_t;

  // Registered read data: the cell value and the neighbors' excited bits.
  typedef struct packed {
    state_t own;
    logic   left;
    logic   right;
    logic   up;
    logic   down;
  } nbr_data_t;

endpackage

### sv/elcu_bank.sv
// One generation bank: cell values plus two copies of the excited-bit map.
module elcu_bank (
  input  logic                clk,
  input  logic                we,
  input  elcu_pkg::addr_t     waddr,
  input  elcu_pkg::state_t    wdata,
  input  logic                re,
  input  elcu_pkg::nbr_addr_t raddr,
  output elcu_pkg::nbr_data_t rdata
);
  import elcu_pkg::*;

  state_t val_mem [CELLS];
  logic   exa_mem [CELLS];
  logic   exb_mem [CELLS];

  // Single write port; the excited bit is kept beside the value.
  always_ff @(posedge clk) begin
    if (we) begin
      val_mem[waddr] <= wdata;
      exa_mem[waddr] <= (wdata == STATE_EXCITED);
      exb_mem[waddr] <= (wdata == STATE_EXCITED);
    end
  end

  // Registered reads: the cell value, left/right from one copy, up/down from the other.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata.own   <= val_mem[raddr.own];
      rdata.left  <= exa_mem[raddr.left];
      rdata.right <= exa_mem[raddr.right];
      rdata.up    <= exb_mem[raddr.up];
      rdata.down  <= exb_mem[raddr.down];
    end
  end

endmodule

### sv/excitable_lattice_cell_update.sv
// Top level of the excitable lattice cell update pipeline.
//
//   channel  direction  handshake             word
//   in       input      in_valid / in_stall   action row col defective coupled_down random_draw
//   out      output     out_valid / out_stall new_state excited generation_done
//   cfg      input      cfg_write             cfg_index cfg_data
//
// One word enters per cycle while in_stall is low; each word passes the address stage,
// the bank read stage and the output register before its result leaves.
// After reset a clearing pass over all 16384 cells fills the banks and maps; input is stalled.
// After the last cell of a generation, input stalls until that cell is written and the
// background clear of the spare bank (a pass over all 16384 cells, begun at the previous swap) has finished.
// A stall on the output lets bubbles close up; nothing is lost or repeated.
module excitable_lattice_cell_update (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   action,
  input  logic [6:0]             row,
  input  logic [6:0]             col,
  input  logic                   defective,
  input  logic                   coupled_down,
  input  logic [15:0]            random_draw,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [10:0]     new_state,
  output logic                   excited,
  output logic                   generation_done,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data
);
  import elcu_pkg::*;

  // Configuration registers.
  logic [9:0]  refractory_period;
  logic [9:0]  pacemaker_period;
  logic [15:0] failure_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      refractory_period <= RST_REFRACTORY;
      pacemaker_period  <= RST_PACEMAKER;
      failure_threshold <= RST_THRESHOLD;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_REFRACTORY: refractory_period <= cfg_data[9:0];
        REG_PACEMAKER:  pacemaker_period  <= cfg_data[9:0];
        REG_THRESHOLD:  failure_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage enables: each stage moves when it is empty or the next one moves.
  logic v1, v2, v3;
  logic en1, en2, en3;
  logic swap_pend, last_written, sweep_busy, init_busy;
  logic accept;

  assign en3      = !v3 || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1 || swap_pend || init_busy;
  assign accept   = in_valid && !in_stall;

  // Stage 1: input word.
  logic        s1_act, s1_dft, s1_cpl;
  coord_t      s1_row, s1_col;
  logic [15:0] s1_draw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_act  <= action;
      s1_row  <= row[CW-1:0];
      s1_col  <= col[CW-1:0];
      s1_dft  <= defective;
      s1_cpl  <= coupled_down;
      s1_draw <= random_draw;
    end
  end

  // Neighbor addresses with vertical wrap.
  coord_t    row_up, row_dn;
  nbr_addr_t s1_addr;
  logic      s1_inr, s1_col0, s1_lastcol, s1_lastcell;

  always_comb begin
    row_up      = (s1_row == coord_t'(0)) ? coord_t'(GRID_SIZE - 1) : coord_t'(s1_row - 1'b1);
    row_dn      = (s1_row == coord_t'(GRID_SIZE - 1)) ? coord_t'(0) : coord_t'(s1_row + 1'b1);
    s1_addr.own   = {s1_row, s1_col};
    s1_addr.left  = {s1_row, coord_t'(s1_col - 1'b1)};
    s1_addr.right = {s1_row, coord_t'(s1_col + 1'b1)};
    s1_addr.up    = {row_up, s1_col};
    s1_addr.down  = {row_dn, s1_col};
    s1_inr      = (int'(s1_row) < GRID_SIZE) && (int'(s1_col) < GRID_SIZE);
    s1_col0     = (s1_col == coord_t'(0));
    s1_lastcol  = (s1_col == coord_t'(GRID_SIZE - 1));
    s1_lastcell = s1_lastcol && (s1_row == coord_t'(GRID_SIZE - 1));
  end

  // Sweep counter shared by the reset fill and the spare-bank clear.
  addr_t sweep_cnt;

  // Defect and coupling maps; loads write in the same stage where updates read.
  logic dft_mem [CELLS];
  logic cpl_mem [CELLS];
  logic s2_dft_own, s2_cpl_own, s2_cpl_up;
  logic map_we;
  addr_t map_waddr;

  assign map_we    = init_busy || (v1 && en2 && s1_act == ACT_LOAD && s1_inr);
  assign map_waddr = init_busy ? sweep_cnt : s1_addr.own;

  always_ff @(posedge clk) begin
    if (map_we) begin
      dft_mem[map_waddr] <= init_busy ? 1'b0 : s1_dft;
      cpl_mem[map_waddr] <= init_busy ? 1'b0 : s1_cpl;
    end
    if (en2) begin
      s2_dft_own <= dft_mem[s1_addr.own];
      s2_cpl_own <= cpl_mem[s1_addr.own];
      s2_cpl_up  <= cpl_mem[s1_addr.up];
    end
  end

  // Stage 2 control.
  logic        s2_act, s2_inr, s2_col0, s2_lastcol, s2_lastcell;
  logic [15:0] s2_draw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_act      <= s1_act;
      s2_inr      <= s1_inr;
      s2_col0     <= s1_col0;
      s2_lastcol  <= s1_lastcol;
      s2_lastcell <= s1_lastcell;
      s2_draw     <= s1_draw;
    end
  end

  // Three banks rotate as current, next and spare.
  bank_t     cur_b, nxt_b, free_b;
  addr_t     s2_idx;
  logic      item_wr;
  state_t    s2_val;
  logic      bank_we    [3];
  addr_t     bank_waddr [3];
  state_t    bank_wdata [3];
  nbr_data_t bank_rd    [3];

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_idx <= s1_addr.own;
    end
  end

  assign item_wr = v2 && en3 && s2_act == ACT_UPDATE && s2_inr;

  // Bank write sources: reset fill, spare-bank clear, next-generation write.
  always_comb begin
    for (int b = 0; b < 3; b++) begin
      bank_we[b]    = 1'b0;
      bank_waddr[b] = sweep_cnt;
      bank_wdata[b] = STATE_REST;
      if (init_busy) begin
        bank_we[b] = 1'b1;
        if (b == 0 && sweep_cnt[CW-1:0] == coord_t'(0)) begin
          bank_wdata[b] = STATE_EXCITED;
        end
      end else if (sweep_busy && bank_t'(b) == free_b) begin
        bank_we[b] = 1'b1;
      end else if (item_wr && bank_t'(b) == nxt_b) begin
        bank_we[b]    = 1'b1;
        bank_waddr[b] = s2_idx;
        bank_wdata[b] = s2_val;
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_bank
    elcu_bank u_bank (
      .clk   (clk),
      .we    (bank_we[g]),
      .waddr (bank_waddr[g]),
      .wdata (bank_wdata[g]),
      .re    (en2),
      .raddr (s1_addr),
      .rdata (bank_rd[g])
    );
  end

  // Current-generation read data.
  nbr_data_t cur_rd;

  always_comb begin
    case (cur_b)
      BANK0:   cur_rd = bank_rd[0];
      BANK1:   cur_rd = bank_rd[1];
      BANK2:   cur_rd = bank_rd[2];
      default: cur_rd = bank_rd[0];
    endcase
  end

  // Next-state rules for pacemakers and ordinary cells; a load word reports the cell's current value.
  state_t pm_next, cell_next;
  logic   trigger;

  always_comb begin
    if (cur_rd.own == STATE_EXCITED) begin
      pm_next = -$signed({1'b0, pacemaker_period});
    end else if (cur_rd.own == STATE_LAST) begin
      pm_next = STATE_EXCITED;
    end else begin
      pm_next = cur_rd.own + state_t'(1);
    end

    trigger = cur_rd.left || (!s2_lastcol && cur_rd.right) ||
              (s2_cpl_own && cur_rd.down) || (s2_cpl_up && cur_rd.up);

    if (cur_rd.own == STATE_EXCITED) begin
      cell_next = -$signed({1'b0, refractory_period});
    end else if (cur_rd.own < 0) begin
      cell_next = cur_rd.own + state_t'(1);
    end else if (cur_rd.own != STATE_REST || !trigger) begin
      cell_next = STATE_REST;
    end else if (s2_dft_own && s2_draw < failure_threshold) begin
      cell_next = STATE_REST;
    end else begin
      cell_next = STATE_EXCITED;
    end

    if (!s2_inr) begin
      s2_val = STATE_REST;
    end else if (s2_act == ACT_LOAD) begin
      s2_val = cur_rd.own;
    end else if (s2_col0) begin
      s2_val = pm_next;
    end else begin
      s2_val = cell_next;
    end
  end

  // Stage 3: output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      new_state       <= s2_val;
      excited         <= (s2_val == STATE_EXCITED);
      generation_done <= s2_inr && s2_act == ACT_UPDATE && s2_lastcell;
    end
  end

  assign out_valid = v3;

  // Generation swap and spare-bank clearing.
  logic swap_go;
  logic last_in;

  assign last_in = accept && action == ACT_UPDATE &&
                   row == 7'(GRID_SIZE - 1) && col == 7'(GRID_SIZE - 1);
  assign swap_go = swap_pend && last_written && !sweep_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_pend    <= 1'b0;
      last_written <= 1'b0;
      sweep_busy   <= 1'b1;
      init_busy    <= 1'b1;
      sweep_cnt    <= '0;
      cur_b        <= BANK0;
      nxt_b        <= BANK1;
      free_b       <= BANK2;
    end else begin
      if (last_in) begin
        swap_pend <= 1'b1;
      end
      if (item_wr && s2_lastcell) begin
        last_written <= 1'b1;
      end
      if (sweep_busy) begin
        sweep_cnt <= addr_t'(sweep_cnt + 1'b1);
        if (sweep_cnt == addr_t'(CELLS - 1)) begin
          sweep_busy <= 1'b0;
          init_busy  <= 1'b0;
        end
      end
      if (swap_go) begin
        swap_pend    <= 1'b0;
        last_written <= 1'b0;
        sweep_busy   <= 1'b1;
        sweep_cnt    <= '0;
        cur_b        <= nxt_b;
        nxt_b        <= free_b;
        free_b       <= cur_b;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // Banks swap only with no word in the read or write stages.
  a_swap_drained: assert property (@(posedge clk) disable iff (rst)
    swap_go |-> (!v1 && !v2))
    else $error("generation swap with words in flight");

  // The three bank roles stay distinct.
  a_banks_distinct: assert property (@(posedge clk) disable iff (rst)
    (cur_b != nxt_b) && (nxt_b != free_b) && (cur_b != free_b))
    else $error("bank roles overlap");

  // No word is taken during the reset fill or while a swap waits.
  a_no_accept_blocked: assert property (@(posedge clk) disable iff (rst)
    (init_busy || swap_pend) |-> in_stall)
    else $error("word accepted while blocked");

  // The spare bank is never written by an item.
  a_spare_clean: assert property (@(posedge clk) disable iff (rst)
    item_wr |-> (nxt_b != free_b) && !init_busy)
    else $error("item write into spare bank");
`endif

endmodule

### tb/sv/excitable_lattice_cell_update_tb.sv
// Self-checking testbench for the excitable lattice cell update block.
`timescale 1ns / 100ps

module excitable_lattice_cell_update_tb;
  import elcu_pkg::*;

  localparam int  LIMIT_CYCLES = 12000000;
  localparam int  TARGET_WORDS = 1900;
  localparam int  SETTLE       = 12;

  typedef struct {
    logic        action;
    logic [6:0]  row;
    logic [6:0]  col;
    logic        defective;
    logic        coupled_down;
    logic [15:0] random_draw;
  } cell_word_t;

  typedef struct {
    state_t st;
    logic   exc;
    logic   done;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = ACT_LOAD;
  logic [6:0] row = '0;
  logic [6:0] col = '0;
  logic defective = 1'b0;
  logic coupled_down = 1'b0;
  logic [15:0] random_draw = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [10:0] new_state;
  logic excited;
  logic generation_done;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_REFRACTORY;
  logic [15:0] cfg_data = '0;

  excitable_lattice_cell_update u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .row(row), .col(col), .defective(defective),
    .coupled_down(coupled_down), .random_draw(random_draw),
    .out_valid(out_valid), .out_stall(out_stall),
    .new_state(new_state), .excited(excited), .generation_done(generation_done),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Local copy of the lattice and its settings.
  state_t      cur_gen [CELLS];
  state_t      nxt_gen [CELLS];
  logic        defect_bits [CELLS];
  logic        couple_bits [CELLS];
  logic [9:0]  refr_len;
  logic [9:0]  pace_len;
  logic [15:0] fail_thr;

  cell_word_t   pending_words[$];
  cell_result_t expected_cells[$];
  int words_taken = 0;
  int results_seen = 0;
  int swaps_seen = 0;
  int mismatches = 0;
  int cycles = 0;
  int phases_run = 0;
  bit word_taken = 1'b0;

  function automatic logic fires(int r, int c);
    return cur_gen[r * GRID_SIZE + c] == STATE_EXCITED;
  endfunction

  // Next state of one ordinary (non-pacemaker) cell.
  function automatic state_t cell_rule(int r, int c, logic [15:0] draw);
    int     idx;
    int     up;
    int     dn;
    logic   trig;
    state_t s;
    idx = r * GRID_SIZE + c;
    up = (r + GRID_SIZE - 1) % GRID_SIZE;
    dn = (r + 1) % GRID_SIZE;
    s = cur_gen[idx];
    if (s == STATE_EXCITED) return -state_t'({1'b0, refr_len});
    if (s < 0) return s + state_t'(1);
    if (s != STATE_REST) return STATE_REST;
    trig = fires(r, c - 1);
    if (c + 1 < GRID_SIZE && fires(r, c + 1)) trig = 1'b1;
    if (couple_bits[idx] && fires(dn, c)) trig = 1'b1;
    if (couple_bits[up * GRID_SIZE + c] && fires(up, c)) trig = 1'b1;
    if (!trig) return STATE_REST;
    if (defect_bits[idx] && draw < fail_thr) return STATE_REST;
    return STATE_EXCITED;
  endfunction

  // Apply one accepted word to the local lattice and give its result.
  function automatic cell_result_t lattice_step(cell_word_t w);
    cell_result_t res;
    int     idx;
    state_t v;
    idx = w.row * GRID_SIZE + w.col;
    res.done = 1'b0;
    if (w.action == ACT_LOAD) begin
      defect_bits[idx] = w.defective;
      couple_bits[idx] = w.coupled_down;
      v = cur_gen[idx];
    end else begin
      if (w.col == 0) begin
        if (cur_gen[idx] == STATE_EXCITED) v = -state_t'({1'b0, pace_len});
        else if (cur_gen[idx] == STATE_LAST) v = STATE_EXCITED;
        else v = cur_gen[idx] + state_t'(1);
      end else begin
        v = cell_rule(w.row, w.col, w.random_draw);
      end
      nxt_gen[idx] = v;
      if (w.row == GRID_SIZE - 1 && w.col == GRID_SIZE - 1) begin
        for (int i = 0; i < CELLS; i++) begin
          cur_gen[i] = nxt_gen[i];
          nxt_gen[i] = STATE_REST;
        end
        res.done = 1'b1;
      end
    end
    res.st = v;
    res.exc = (v == STATE_EXCITED);
    return res;
  endfunction

  // Acceptance, register writes, result checking and the cycle limit.
  always @(posedge clk) begin
    cell_result_t want;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
    if (cfg_write) begin
      case (cfg_index)
        REG_REFRACTORY: refr_len = cfg_data[9:0];
        REG_PACEMAKER:  pace_len = cfg_data[9:0];
        REG_THRESHOLD:  fail_thr = cfg_data;
        default: ;
      endcase
    end
    word_taken = 1'b0;
    if (!rst && in_valid && !in_stall) begin
      expected_cells.push_back(lattice_step(pending_words.pop_front()));
      words_taken++;
      word_taken = 1'b1;
    end
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (generation_done) swaps_seen++;
      if (expected_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: state %0d", new_state);
      end else begin
        want = expected_cells.pop_front();
        if (new_state !== want.st || excited !== want.exc || generation_done !== want.done)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch #%0d: exp state %0d exc %b done %b, got %0d %b %b",
                     results_seen, want.st, want.exc, want.done,
                     new_state, excited, generation_done);
        end
      end
    end
  end

  // Sender: bursts of words separated by random gaps; a held word never changes.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    logic hold;
    hold = in_valid && !word_taken;
    if (!hold) begin
      if (gap_left > 0 || pending_words.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        in_valid     <= 1'b1;
        action       <= pending_words[0].action;
        row          <= pending_words[0].row;
        col          <= pending_words[0].col;
        defective    <= pending_words[0].defective;
        coupled_down <= pending_words[0].coupled_down;
        random_draw  <= pending_words[0].random_draw;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver: a stall pattern that changes mode, plus one long hold-off.
  int stall_mode = 0;
  int mode_left = 0;
  int holdoff_left = 0;
  bit held_once = 0;
  always @(negedge clk) begin
    if (!held_once && words_taken >= 600) begin
      held_once = 1;
      holdoff_left = 500;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(16, 96);
    end else begin
      mode_left--;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic cell_word_t make_word(logic act, int r, int c, logic d, logic cp,
                                           logic [15:0] draw);
    cell_word_t w;
    w.action = act;
    w.row = r[6:0];
    w.col = c[6:0];
    w.defective = d;
    w.coupled_down = cp;
    w.random_draw = draw;
    return w;
  endfunction

  function automatic cell_word_t noise_word();
    return make_word(1'($urandom_range(0, 1)), $urandom_range(0, 127),
                     $urandom_range(0, 127), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
  endfunction

  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_cells.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] refr, logic [15:0] pace, logic [15:0] thr);
    @(negedge clk);
    cfg_write <= 1'b1; cfg_index <= REG_REFRACTORY; cfg_data <= refr;
    @(negedge clk);
    cfg_index <= REG_PACEMAKER; cfg_data <= pace;
    @(negedge clk);
    cfg_index <= REG_THRESHOLD; cfg_data <= thr;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // One phase: a window of cells loaded, then stepped for a few generations.
  task automatic run_phase();
    int r0;
    int c0;
    int nr;
    int nc;
    int gens;
    int rr;
    nr = $urandom_range(3, 6);
    nc = $urandom_range(6, 14);
    r0 = $urandom_range(0, 127);
    case ($urandom_range(0, 3))
      0, 1: c0 = 0;
      2: c0 = GRID_SIZE - nc;
      default: c0 = $urandom_range(0, GRID_SIZE - nc);
    endcase
    for (int i = 0; i < nr; i++)
      for (int j = 0; j < nc; j++)
        if ($urandom_range(0, 1))
          pending_words.push_back(make_word(ACT_LOAD, (r0 + i) % GRID_SIZE, c0 + j,
                                  $urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)),
                                  16'($urandom_range(0, 65535))));
    gens = $urandom_range(3, 6);
    for (int g = 0; g < gens; g++) begin
      for (int i = 0; i < nr; i++) begin
        rr = (r0 + i) % GRID_SIZE;
        for (int j = 0; j < nc; j++) begin
          if ($urandom_range(0, 19) == 0) pending_words.push_back(noise_word());
          pending_words.push_back(make_word(ACT_UPDATE, rr, c0 + j,
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  16'($urandom_range(0, 65535))));
        end
      end
      // Closing the generation; occasionally skipped to merge two.
      if ($urandom_range(0, 9) != 0)
        pending_words.push_back(make_word(ACT_UPDATE, 127, 127, 0, 0,
                                          16'($urandom_range(0, 65535))));
    end
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      cur_gen[i] = (i % GRID_SIZE == 0) ? STATE_EXCITED : STATE_REST;
      nxt_gen[i] = STATE_REST;
      defect_bits[i] = 1'b0;
      couple_bits[i] = 1'b0;
    end
    refr_len = RST_REFRACTORY;
    pace_len = RST_PACEMAKER;
    fail_thr = RST_THRESHOLD;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words at reset settings: corners, defects, couplings, last column, swap.
    pending_words.push_back(make_word(ACT_LOAD, 0, 0, 1, 1, 16'hFFFF));
    pending_words.push_back(make_word(ACT_LOAD, 127, 127, 1, 1, 16'h0000));
    pending_words.push_back(make_word(ACT_LOAD, 0, 1, 1, 1, 16'h0000));
    pending_words.push_back(make_word(ACT_LOAD, 1, 1, 1, 0, 16'hFFFF));
    pending_words.push_back(make_word(ACT_LOAD, 127, 1, 0, 1, 16'h0000));
    pending_words.push_back(make_word(ACT_UPDATE, 0, 0, 1, 1, 16'h0000));
    pending_words.push_back(make_word(ACT_UPDATE, 0, 1, 0, 0, 16'h0000));
    pending_words.push_back(make_word(ACT_UPDATE, 1, 1, 0, 0, 16'hFFFF));
    pending_words.push_back(make_word(ACT_UPDATE, 127, 1, 0, 0, 16'h0CCC));
    pending_words.push_back(make_word(ACT_UPDATE, 0, 126, 0, 0, 16'h0000));
    pending_words.push_back(make_word(ACT_UPDATE, 0, 127, 0, 0, 16'h0000));
    pending_words.push_back(make_word(ACT_UPDATE, 127, 127, 0, 0, 16'h1234));
    pending_words.push_back(make_word(ACT_LOAD, 1, 1, 1, 0, 16'h0000));
    pending_words.push_back(make_word(ACT_LOAD, 0, 0, 0, 0, 16'h0000));
    pending_words.push_back(make_word(ACT_UPDATE, 0, 0, 0, 0, 16'h0000));
    pending_words.push_back(make_word(ACT_UPDATE, 0, 1, 0, 0, 16'h0000));
    pending_words.push_back(make_word(ACT_UPDATE, 0, 2, 0, 0, 16'hFFFF));
    pending_words.push_back(make_word(ACT_UPDATE, 127, 127, 0, 0, 16'h0000));
    drain();

    // Random phases, the first ones at the register extremes and at zero periods.
    while (words_taken < TARGET_WORDS) begin
      case (phases_run)
        0: set_regs(16'd1, 16'd2, 16'd0);
        1: set_regs(16'd1023, 16'd1023, 16'hFFFF);
        2: set_regs(16'd0, 16'd0, 16'($urandom_range(0, 65535)));
        3: set_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)));
        default: set_regs(16'($urandom_range(1, 12)), 16'($urandom_range(2, 16)),
                          16'($urandom_range(0, 65535)));
      endcase
      run_phase();
      drain();
      phases_run++;
    end

    repeat (40) @(posedge clk);
    $display("Covered %0d words over %0d register phases, %0d generation swaps, %0d results.",
             words_taken, phases_run, swaps_seen, results_seen);
    if (mismatches == 0 && expected_cells.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_cells.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
sv/elcu_pkg.sv
sv/elcu_bank.sv
sv/excitable_lattice_cell_update.sv
tb/sv/excitable_lattice_cell_update_tb.sv
